/* design/mhms_pkg.sv */
package mhms_pkg;

    localparam int TIMER_BITS_DEF = 17;
    localparam int CFG_W          = 16;
    localparam int CFG_IDX_W      = 3;
    localparam int STATE_W        = 3;
    localparam int NUM_POS        = 5;

    // sequencer state codes
    localparam logic [STATE_W-1:0] ST_UNINIT   = 3'd0;
    localparam logic [STATE_W-1:0] ST_HOMING   = 3'd1;
    localparam logic [STATE_W-1:0] ST_MOVING   = 3'd2;
    localparam logic [STATE_W-1:0] ST_DONE     = 3'd3;
    localparam logic [STATE_W-1:0] ST_ERR_HOME = 3'd4;
    localparam logic [STATE_W-1:0] ST_ERR_MOVE = 3'd5;
    localparam logic [STATE_W-1:0] ST_ESTOP    = 3'd6;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_POS_ONE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_POS_TWO    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_POS_THREE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_POS_FOUR   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_POS_FIVE   = 3'd6;

    localparam logic [CFG_W-1:0] TIMEOUT_RST = 16'd5000;
    localparam logic [CFG_W-1:0] SETTLE_RST  = 16'd100;

    // requested position selectors
    localparam logic [15:0] REQ_POS_ONE   = 16'd1;
    localparam logic [15:0] REQ_POS_TWO   = 16'd2;
    localparam logic [15:0] REQ_POS_THREE = 16'd3;
    localparam logic [15:0] REQ_POS_FOUR  = 16'd4;
    localparam logic [15:0] REQ_POS_FIVE  = 16'd5;
    localparam logic [15:0] HOME_DISTANCE = 16'd0;

    typedef struct packed {
        logic [CFG_W-1:0]               timeout_ms;
        logic [CFG_W-1:0]               settle_allowance_ms;
        logic [NUM_POS-1:0][CFG_W-1:0]  positions;
    } cfg_t;

    typedef struct packed {
        logic        estop_pressed;
        logic        pos_cmd_written;
        logic        torq_cmd_written;
        logic [15:0] requested_position;
        logic        right_feedback_asserted;
        logic        right_steps_complete;
        logic        left_feedback_asserted;
        logic        left_steps_complete;
    } item_t;

    typedef struct packed {
        logic [STATE_W-1:0] state_code;
        logic               motors_enable;
        logic [15:0]        target_distance;
        logic               start_move;
        logic               clear_alerts;
        logic               zero_position_ref;
    } result_t;

    function automatic logic [CFG_W-1:0] select_distance(
        input logic [NUM_POS-1:0][CFG_W-1:0] positions,
        input logic [15:0]                   req
    );
        logic [CFG_W-1:0] sel;
        case (req)
            REQ_POS_ONE:   sel = positions[0];
            REQ_POS_TWO:   sel = positions[1];
            REQ_POS_THREE: sel = positions[2];
            REQ_POS_FOUR:  sel = positions[3];
            REQ_POS_FIVE:  sel = positions[4];
            default:       sel = HOME_DISTANCE;
        endcase
        return sel;
    endfunction

endpackage

/* design/mhms_cfg_regs.sv */
module mhms_cfg_regs
    import mhms_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [CFG_IDX_W-1:0] wr_index,
    input  logic [CFG_W-1:0]     wr_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                CFG_TIMEOUT:   cfg_next.timeout_ms          = wr_data;
                CFG_SETTLE:    cfg_next.settle_allowance_ms = wr_data;
                CFG_POS_ONE:   cfg_next.positions[0]        = wr_data;
                CFG_POS_TWO:   cfg_next.positions[1]        = wr_data;
                CFG_POS_THREE: cfg_next.positions[2]        = wr_data;
                CFG_POS_FOUR:  cfg_next.positions[3]        = wr_data;
                CFG_POS_FIVE:  cfg_next.positions[4]        = wr_data;
                default:       cfg_next = cfg_reg;   // drop writes past the list
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.timeout_ms          <= TIMEOUT_RST;
            cfg_reg.settle_allowance_ms <= SETTLE_RST;
            cfg_reg.positions           <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* design/mhms_seq_core.sv */
module mhms_seq_core
    import mhms_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t result
);

    // compare width: one bit above the wider of timer and register
    localparam int CMP_W = ((TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W) + 1;

    logic [STATE_W-1:0]    state_reg, state_next;
    logic [TIMER_BITS-1:0] elapsed_reg, elapsed_next;
    logic                  pos_pend_reg, pos_pend_next;
    logic                  torq_pend_reg, torq_pend_next;
    logic                  enable_reg, enable_next;
    logic [CFG_W-1:0]      dist_reg, dist_next;

    logic [TIMER_BITS-1:0] elapsed_inc;
    logic [CMP_W-1:0]      elapsed_ext;
    logic                  settled;
    logic                  timed_out;
    logic                  motors_done;
    logic [STATE_W-1:0]    cur_state;
    logic                  start_move;
    logic                  clear_alerts;
    logic                  zero_ref;

    // saturate at all ones
    assign elapsed_inc = (&elapsed_reg) ? elapsed_reg : elapsed_reg + TIMER_BITS'(1);
    assign elapsed_ext = CMP_W'(elapsed_inc);
    assign settled     = elapsed_ext > CMP_W'(cfg.settle_allowance_ms);
    assign timed_out   = elapsed_ext > CMP_W'(cfg.timeout_ms);
    assign motors_done = item.right_feedback_asserted & item.right_steps_complete
                       & item.left_feedback_asserted & item.left_steps_complete;
    assign cur_state   = item.estop_pressed ? ST_ESTOP : state_reg;

    always_comb
    begin
        state_next     = cur_state;
        elapsed_next   = elapsed_inc;
        pos_pend_next  = pos_pend_reg | item.pos_cmd_written;
        torq_pend_next = torq_pend_reg | item.torq_cmd_written;
        enable_next    = enable_reg;
        dist_next      = dist_reg;
        start_move     = 1'b0;
        clear_alerts   = 1'b0;
        zero_ref       = 1'b0;

        case (cur_state)
            ST_UNINIT:
            begin
                enable_next = 1'b0;
                if (pos_pend_next)
                begin
                    pos_pend_next = 1'b0;
                    clear_alerts  = 1'b1;
                    enable_next   = 1'b1;
                    elapsed_next  = '0;
                    state_next    = ST_HOMING;
                end
            end
            ST_HOMING:
            begin
                if (motors_done && settled)
                begin
                    zero_ref     = 1'b1;
                    dist_next    = select_distance(cfg.positions, item.requested_position);
                    start_move   = 1'b1;
                    elapsed_next = '0;
                    state_next   = ST_MOVING;
                end
                else if (timed_out)
                begin
                    state_next = ST_ERR_HOME;
                end
            end
            ST_MOVING:
            begin
                if (motors_done && settled)
                    state_next = ST_DONE;
                else if (timed_out)
                    state_next = ST_ERR_MOVE;
            end
            ST_DONE:
            begin
                // a torque command re-targets but leaves the state alone
                if (pos_pend_next || torq_pend_next)
                begin
                    dist_next    = select_distance(cfg.positions, item.requested_position);
                    start_move   = 1'b1;
                    elapsed_next = '0;
                end
                if (pos_pend_next)
                    state_next = ST_MOVING;
                pos_pend_next  = 1'b0;
                torq_pend_next = 1'b0;
            end
            ST_ERR_HOME, ST_ERR_MOVE:
            begin
                enable_next = 1'b0;
            end
            default:
            begin
                enable_next    = 1'b0;
                pos_pend_next  = 1'b0;
                torq_pend_next = 1'b0;
                state_next     = item.estop_pressed ? ST_ESTOP : ST_UNINIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_UNINIT;
            elapsed_reg   <= '0;
            pos_pend_reg  <= 1'b0;
            torq_pend_reg <= 1'b0;
            enable_reg    <= 1'b0;
            dist_reg      <= '0;
        end
        else if (step)
        begin
            state_reg     <= state_next;
            elapsed_reg   <= elapsed_next;
            pos_pend_reg  <= pos_pend_next;
            torq_pend_reg <= torq_pend_next;
            enable_reg    <= enable_next;
            dist_reg      <= dist_next;
        end
    end

    assign result.state_code        = state_next;
    assign result.motors_enable     = enable_next;
    assign result.target_distance   = dist_next;
    assign result.start_move        = start_move;
    assign result.clear_alerts      = clear_alerts;
    assign result.zero_position_ref = zero_ref;

    a_estop_wins: assert property (@(posedge clk) disable iff (!rst_n)
        step && item.estop_pressed |=> state_reg == ST_ESTOP && !enable_reg)
        else $error("estop tick did not reach estop state");

    a_start_clears_timer: assert property (@(posedge clk) disable iff (!rst_n)
        step && start_move |=> elapsed_reg == '0)
        else $error("move start did not clear timer");

    a_home_to_move: assert property (@(posedge clk) disable iff (!rst_n)
        step && zero_ref |=> state_reg == ST_MOVING && enable_reg)
        else $error("homing finish did not start a move");

    a_error_drops_enable: assert property (@(posedge clk) disable iff (!rst_n)
        step && (state_reg == ST_ERR_HOME || state_reg == ST_ERR_MOVE) |=> !enable_reg)
        else $error("error state kept motors enabled");

endmodule

/* design/motion_homing_move_sequencer_top.sv */
// Homing and move sequencer for two motors, fed one transaction per 1 ms tick.
// A tick enters an input register, the sequencer state is updated from it and
// the result lands in an output register. A new tick can be taken every cycle
// while out_stall does not hold back the output register. in_stall rises only
// while a finished result is held by out_stall and the input register is full.
// Configuration writes (cfg_ready is always high) must be made while no tick
// is in flight; indexes past the last register are ignored. There is no
// clearing pass after reset.
module motion_homing_move_sequencer_top
    import mhms_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,

    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 estop_pressed,
    input  logic                 pos_cmd_written,
    input  logic                 torq_cmd_written,
    input  logic [15:0]          requested_position,
    input  logic                 right_feedback_asserted,
    input  logic                 right_steps_complete,
    input  logic                 left_feedback_asserted,
    input  logic                 left_steps_complete,

    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [STATE_W-1:0]   state_code,
    output logic                 motors_enable,
    output logic [15:0]          target_distance,
    output logic                 start_move,
    output logic                 clear_alerts,
    output logic                 zero_position_ref
);

    cfg_t    cfg;
    item_t   item_reg;
    item_t   item_in;
    logic    item_valid_reg, item_valid_next;
    result_t res_comb;
    result_t res_reg;
    logic    res_valid_reg, res_valid_next;
    logic    advance;
    logic    in_accept;

    assign cfg_ready = 1'b1;

    mhms_cfg_regs u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    assign item_in.estop_pressed           = estop_pressed;
    assign item_in.pos_cmd_written         = pos_cmd_written;
    assign item_in.torq_cmd_written        = torq_cmd_written;
    assign item_in.requested_position      = requested_position;
    assign item_in.right_feedback_asserted = right_feedback_asserted;
    assign item_in.right_steps_complete    = right_steps_complete;
    assign item_in.left_feedback_asserted  = left_feedback_asserted;
    assign item_in.left_steps_complete     = left_steps_complete;

    // move the held tick on when the output register is free or being drained
    assign advance   = item_valid_reg && (!res_valid_reg || !out_stall);
    assign in_stall  = item_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (in_accept)
            item_valid_next = 1'b1;
        else if (advance)
            item_valid_next = 1'b0;

        res_valid_next = res_valid_reg;
        if (advance)
            res_valid_next = 1'b1;
        else if (!out_stall)
            res_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
            item_reg <= item_in;
        if (advance)
            res_reg <= res_comb;
    end

    mhms_seq_core #(
        .TIMER_BITS (TIMER_BITS)
    ) u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (item_reg),
        .cfg    (cfg),
        .result (res_comb)
    );

    assign out_valid         = res_valid_reg;
    assign state_code        = res_reg.state_code;
    assign motors_enable     = res_reg.motors_enable;
    assign target_distance   = res_reg.target_distance;
    assign start_move        = res_reg.start_move;
    assign clear_alerts      = res_reg.clear_alerts;
    assign zero_position_ref = res_reg.zero_position_ref;

endmodule

/* bench/motion_homing_move_sequencer_top_test.sv */
`timescale 1ns / 100ps

module motion_homing_move_sequencer_top_test;

    import mhms_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
    localparam logic [3:0] ALL_DONE = 4'hF;
    localparam logic [3:0] NO_FLAGS = 4'h0;
    localparam logic [3:0] LEFT_BUSY = 4'hE;
    localparam int WATCHDOG_LIMIT = 2000;

    class sequencer_scoreboard;
        logic [CFG_W-1:0]          timeout_ms;
        logic [CFG_W-1:0]          settle_ms;
        logic [CFG_W-1:0]          pos_dist [NUM_POS];
        logic [STATE_W-1:0]        seq;
        logic [TIMER_BITS_DEF-1:0] elapsed;
        bit                        pos_pend;
        bit                        torq_pend;
        bit                        enable;
        logic [15:0]               target;
        result_t                   predicted_outputs [$];
        int                        errors;

        function new();
            timeout_ms = TIMEOUT_RST;
            settle_ms  = SETTLE_RST;
            foreach (pos_dist[i]) pos_dist[i] = '0;
            seq       = ST_UNINIT;
            elapsed   = '0;
            pos_pend  = 1'b0;
            torq_pend = 1'b0;
            enable    = 1'b0;
            target    = '0;
            errors    = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
            case (idx)
                CFG_TIMEOUT:   timeout_ms = v;
                CFG_SETTLE:    settle_ms = v;
                CFG_POS_ONE,
                CFG_POS_TWO,
                CFG_POS_THREE,
                CFG_POS_FOUR,
                CFG_POS_FIVE:  pos_dist[idx - CFG_POS_ONE] = v;
                default:       ;
            endcase
        endfunction

        function logic [15:0] distance_for(logic [15:0] req);
            if (req >= REQ_POS_ONE && req <= REQ_POS_FIVE)
                return pos_dist[req - REQ_POS_ONE];
            return HOME_DISTANCE;
        endfunction

        function int outstanding();
            return predicted_outputs.size();
        endfunction

        // Advance the sequencer by one tick and queue the output it should give.
        function void predict_tick(item_t t);
            result_t r;
            bit      all_done;
            bit      settled;
            bit      timed_out;
            r = '0;
            all_done = t.right_feedback_asserted && t.right_steps_complete &&
                       t.left_feedback_asserted && t.left_steps_complete;
            if (t.pos_cmd_written) pos_pend = 1'b1;
            if (t.torq_cmd_written) torq_pend = 1'b1;
            if (elapsed != '1) elapsed = elapsed + 1'b1;
            settled   = elapsed > settle_ms;
            timed_out = elapsed > timeout_ms;
            if (t.estop_pressed) seq = ST_ESTOP;
            case (seq)
                ST_UNINIT: begin
                    enable = 1'b0;
                    if (pos_pend) begin
                        pos_pend = 1'b0;
                        r.clear_alerts = 1'b1;
                        enable = 1'b1;
                        elapsed = '0;
                        seq = ST_HOMING;
                    end
                end
                ST_HOMING: begin
                    if (all_done && settled) begin
                        r.zero_position_ref = 1'b1;
                        r.start_move = 1'b1;
                        target = distance_for(t.requested_position);
                        elapsed = '0;
                        seq = ST_MOVING;
                    end else if (timed_out) begin
                        seq = ST_ERR_HOME;
                    end
                end
                ST_MOVING: begin
                    if (all_done && settled)
                        seq = ST_DONE;
                    else if (timed_out)
                        seq = ST_ERR_MOVE;
                end
                ST_DONE: begin
                    if (pos_pend) begin
                        pos_pend = 1'b0;
                        r.start_move = 1'b1;
                        target = distance_for(t.requested_position);
                        elapsed = '0;
                        seq = ST_MOVING;
                    end
                    if (torq_pend) begin
                        torq_pend = 1'b0;
                        r.start_move = 1'b1;
                        target = distance_for(t.requested_position);
                        elapsed = '0;
                    end
                end
                ST_ERR_HOME,
                ST_ERR_MOVE: enable = 1'b0;
                default: begin
                    enable = 1'b0;
                    pos_pend = 1'b0;
                    torq_pend = 1'b0;
                    seq = t.estop_pressed ? ST_ESTOP : ST_UNINIT;
                end
            endcase
            r.state_code      = seq;
            r.motors_enable   = enable;
            r.target_distance = target;
            predicted_outputs.push_back(r);
        endfunction

        function void compare_output(result_t got);
            result_t want;
            if (predicted_outputs.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: output with no tick pending: state %0d dist %0d",
                             $realtime, got.state_code, got.target_distance);
                return;
            end
            want = predicted_outputs.pop_front();
            if (got.state_code !== want.state_code ||
                got.motors_enable !== want.motors_enable ||
                got.target_distance !== want.target_distance ||
                got.start_move !== want.start_move ||
                got.clear_alerts !== want.clear_alerts ||
                got.zero_position_ref !== want.zero_position_ref) begin
                errors++;
                if (errors <= 10) begin
                    $display("%0t: exp state %0d en %0b dist %0d start %0b clr %0b zref %0b",
                             $realtime, want.state_code, want.motors_enable,
                             want.target_distance, want.start_move, want.clear_alerts,
                             want.zero_position_ref);
                    $display("    got state %0d en %0b dist %0d start %0b clr %0b zref %0b",
                             got.state_code, got.motors_enable,
                             got.target_distance, got.start_move, got.clear_alerts,
                             got.zero_position_ref);
                end
            end
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    item_t                tick;
    logic                 out_valid;
    logic                 out_stall;
    logic [STATE_W-1:0]   state_code;
    logic                 motors_enable;
    logic [15:0]          target_distance;
    logic                 start_move;
    logic                 clear_alerts;
    logic                 zero_position_ref;
    result_t              dut_out;

    sequencer_scoreboard sb;
    int send_idle_pct;
    int stall_pct;
    int quiet_cycles = 0;

    assign dut_out = {state_code, motors_enable, target_distance, start_move,
                      clear_alerts, zero_position_ref};

    motion_homing_move_sequencer_top u_dut (
        .clk                     (clk),
        .rst_n                   (rst_n),
        .cfg_valid               (cfg_valid),
        .cfg_ready               (cfg_ready),
        .cfg_index               (cfg_index),
        .cfg_data                (cfg_data),
        .in_valid                (in_valid),
        .in_stall                (in_stall),
        .estop_pressed           (tick.estop_pressed),
        .pos_cmd_written         (tick.pos_cmd_written),
        .torq_cmd_written        (tick.torq_cmd_written),
        .requested_position      (tick.requested_position),
        .right_feedback_asserted (tick.right_feedback_asserted),
        .right_steps_complete    (tick.right_steps_complete),
        .left_feedback_asserted  (tick.left_feedback_asserted),
        .left_steps_complete     (tick.left_steps_complete),
        .out_valid               (out_valid),
        .out_stall               (out_stall),
        .state_code              (state_code),
        .motors_enable           (motors_enable),
        .target_distance         (target_distance),
        .start_move              (start_move),
        .clear_alerts            (clear_alerts),
        .zero_position_ref       (zero_position_ref)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(negedge clk)
    begin
        out_stall = ($urandom_range(0, 99) < stall_pct);
    end

    // Check outputs and watch for a hung handshake.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.compare_output(dut_out);
        if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("motion_homing_move_sequencer_top: mismatch");
            $finish;
        end
    end

    function automatic item_t mk(bit estop, bit pos, bit torq, logic [15:0] req,
                                 logic [3:0] flags);
        item_t t;
        t.estop_pressed           = estop;
        t.pos_cmd_written         = pos;
        t.torq_cmd_written        = torq;
        t.requested_position      = req;
        t.right_feedback_asserted = flags[3];
        t.right_steps_complete    = flags[2];
        t.left_feedback_asserted  = flags[1];
        t.left_steps_complete     = flags[0];
        return t;
    endfunction

    // Mostly well-formed commands for the predicted state, plus some pure noise.
    function automatic item_t next_tick();
        item_t       t;
        logic [3:0]  flags;
        logic [15:0] req;
        bit          estop;
        bit          pos;
        bit          torq;
        flags = 4'($urandom);
        req   = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
        estop = ($urandom_range(0, 99) < 3);
        pos   = ($urandom_range(0, 99) < 8);
        torq  = ($urandom_range(0, 99) < 8);
        if ($urandom_range(0, 99) < 12)
            return mk(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), 16'($urandom), 4'($urandom));
        case (sb.seq)
            ST_UNINIT:
                pos = ($urandom_range(0, 99) < 60);
            ST_HOMING,
            ST_MOVING:
                if ($urandom_range(0, 99) < 45) flags = ALL_DONE;
            ST_DONE: begin
                pos  = ($urandom_range(0, 99) < 35);
                torq = ($urandom_range(0, 99) < 35);
            end
            ST_ERR_HOME,
            ST_ERR_MOVE:
                estop = ($urandom_range(0, 99) < 25);
            default:
                estop = ($urandom_range(0, 99) < 40);
        endcase
        return mk(estop, pos, torq, req, flags);
    endfunction

    function automatic logic [CFG_W-1:0] pick_distance();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            default: return CFG_W'($urandom);
        endcase
    endfunction

    task automatic send_tick(input item_t t);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            @(negedge clk);
            in_valid = 1'b0;
            @(posedge clk);
        end
        @(negedge clk);
        in_valid = 1'b1;
        tick = t;
        do @(posedge clk); while (in_stall);
        sb.predict_tick(t);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] v);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = v;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, v);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Hold the sender until every output is back, then let the pipeline empty.
    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.outstanding() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic configure(input logic [CFG_W-1:0] timeout, input logic [CFG_W-1:0] settle);
        write_reg(CFG_TIMEOUT, timeout);
        write_reg(CFG_SETTLE, settle);
        write_reg(CFG_POS_ONE, pick_distance());
        write_reg(CFG_POS_TWO, pick_distance());
        write_reg(CFG_POS_THREE, pick_distance());
        write_reg(CFG_POS_FOUR, pick_distance());
        write_reg(CFG_POS_FIVE, pick_distance());
    endtask

    task automatic run_phase(input int n, input int idle, input int stall);
        send_idle_pct = idle;
        stall_pct = stall;
        for (int i = 0; i < n; i++) begin
            if (i == n / 2) drain();
            send_tick(next_tick());
        end
        drain();
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        tick = '0;
        send_idle_pct = 0;
        stall_pct = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset configuration: homing cannot settle within a few ticks
        send_tick(mk(1'b0, 1'b0, 1'b0, REQ_POS_ONE, NO_FLAGS));
        send_tick(mk(1'b0, 1'b1, 1'b0, REQ_POS_ONE, NO_FLAGS));
        send_tick(mk(1'b0, 1'b0, 1'b0, REQ_POS_ONE, ALL_DONE));
        send_tick(mk(1'b1, 1'b0, 1'b0, REQ_POS_ONE, ALL_DONE));
        send_tick(mk(1'b0, 1'b0, 1'b0, REQ_POS_ONE, NO_FLAGS));
        drain();

        write_reg(CFG_TIMEOUT, 16'd3);
        write_reg(CFG_SETTLE, 16'd1);
        write_reg(CFG_POS_ONE, 16'hFFFF);
        write_reg(CFG_POS_TWO, 16'h0001);
        write_reg(CFG_POS_THREE, 16'h8000);
        write_reg(CFG_POS_FOUR, 16'h1234);
        write_reg(CFG_POS_FIVE, 16'h00AA);
        write_reg(CFG_UNUSED, 16'hFFFF);

        send_tick(mk(1'b0, 1'b0, 1'b1, REQ_POS_ONE, NO_FLAGS));    // torque held pending
        send_tick(mk(1'b0, 1'b1, 1'b0, REQ_POS_ONE, NO_FLAGS));    // start homing
        send_tick(mk(1'b0, 1'b0, 1'b0, REQ_POS_ONE, ALL_DONE));    // not settled yet
        send_tick(mk(1'b0, 1'b0, 1'b0, REQ_POS_ONE, ALL_DONE));    // homed, move starts
        send_tick(mk(1'b0, 1'b0, 1'b0, REQ_POS_TWO, LEFT_BUSY));
        send_tick(mk(1'b0, 1'b0, 1'b0, REQ_POS_TWO, ALL_DONE));    // move done
        send_tick(mk(1'b0, 1'b0, 1'b0, REQ_POS_THREE, NO_FLAGS));  // pending torque acts
        send_tick(mk(1'b0, 1'b1, 1'b1, REQ_POS_TWO, NO_FLAGS));    // both commands at once
        repeat (4) send_tick(mk(1'b0, 1'b0, 1'b0, REQ_POS_TWO, NO_FLAGS));  // move times out
        send_tick(mk(1'b0, 1'b1, 1'b0, REQ_POS_FOUR, NO_FLAGS));
        send_tick(mk(1'b1, 1'b0, 1'b0, REQ_POS_FOUR, NO_FLAGS));
        send_tick(mk(1'b1, 1'b1, 1'b1, REQ_POS_FOUR, ALL_DONE));
        send_tick(mk(1'b0, 1'b1, 1'b0, REQ_POS_FOUR, ALL_DONE));   // strobe dropped on release
        send_tick(mk(1'b0, 1'b1, 1'b0, 16'hFFFF, NO_FLAGS));
        send_tick(mk(1'b0, 1'b0, 1'b0, 16'hFFFF, ALL_DONE));
        send_tick(mk(1'b0, 1'b0, 1'b0, 16'hFFFF, ALL_DONE));       // out of range, home
        send_tick(mk(1'b0, 1'b0, 1'b0, REQ_POS_FIVE, ALL_DONE));
        send_tick(mk(1'b0, 1'b0, 1'b1, REQ_POS_FIVE, NO_FLAGS));
        send_tick(mk(1'b0, 1'b1, 1'b0, REQ_POS_FOUR, NO_FLAGS));
        send_tick(mk(1'b1, 1'b0, 1'b0, REQ_POS_FOUR, NO_FLAGS));   // stop while moving
        send_tick(mk(1'b0, 1'b0, 1'b0, REQ_POS_FOUR, NO_FLAGS));
        send_tick(mk(1'b0, 1'b1, 1'b0, HOME_DISTANCE, NO_FLAGS));
        repeat (4) send_tick(mk(1'b0, 1'b0, 1'b0, HOME_DISTANCE, NO_FLAGS));  // homing times out
        drain();

        configure(16'd12, 16'd2);
        run_phase(100, 0, 0);
        configure(16'd0, 16'd0);
        run_phase(100, 84, 0);
        configure(16'd30, 16'd6);
        run_phase(100, 0, 84);
        configure(16'hFFFF, 16'd4);
        run_phase(100, 23, 23);
        configure(16'd20, 16'hFFFF);
        run_phase(40, 0, 0);

        repeat (8) @(posedge clk);
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("motion_homing_move_sequencer_top: match");
        else
            $display("motion_homing_move_sequencer_top: mismatch");
        $finish;
    end

endmodule

/* filelist.f */
design/mhms_pkg.sv
design/mhms_cfg_regs.sv
design/mhms_seq_core.sv
design/motion_homing_move_sequencer_top.sv
bench/motion_homing_move_sequencer_top_test.sv
